/* design/csvi_pkg.sv */
package csvi_pkg;

   // Buffer positions wrap at 2**POS_W bytes.
   localparam int POS_W      = 16;
   localparam int FIELDS_MAX = 32;
   localparam int FCNT_W     = $clog2(FIELDS_MAX + 2);
   localparam int ADDR_W     = (FIELDS_MAX > 1) ? $clog2(FIELDS_MAX) : 1;

   // Queue depths must be powers of two.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSP_DEPTH  = 2;
   localparam int RSP_PTR_W  = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] QUOTE_CHAR = 8'h22;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_TUPLE_DELIM = 2'd0;
   localparam logic [1:0] REG_FIELD_DELIM = 2'd1;
   localparam logic [1:0] REG_QUOTE_MODE  = 2'd2;
   localparam logic [1:0] REG_FIELD_COUNT = 2'd3;

   localparam logic [2:0] KIND_FIELD   = 3'd0;
   localparam logic [2:0] KIND_END     = 3'd1;
   localparam logic [2:0] KIND_SUMMARY = 3'd2;
   localparam logic [2:0] KIND_NODELIM = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [POS_W-1:0]  offset;
      logic [POS_W-1:0]  second_offset;
      logic [FCNT_W-1:0] parsed_fields;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        tup_delim;
      logic [7:0]        fld_delim;
      logic              quote_mode;
      logic [FCNT_W-1:0] field_count;
   } cfg_type;

   // One command per byte that causes results.
   typedef struct packed {
      logic              flush;
      logic              error;
      logic              summ;
      logic              have_delim;
      logic [FCNT_W-1:0] count;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  end_pos;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  last;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [POS_W-1:0]  data;
   } store_wr_type;

endpackage

/* design/csvi_csr.sv */
module csvi_csr import csvi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TUPLE_DELIM: cfg_in.tup_delim   = pwdata[7:0];
            REG_FIELD_DELIM: cfg_in.fld_delim   = pwdata[7:0];
            REG_QUOTE_MODE:  cfg_in.quote_mode  = pwdata[0];
            REG_FIELD_COUNT: cfg_in.field_count = pwdata[FCNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TUPLE_DELIM: prdata = CSR_DATA_W'(cfg_ff.tup_delim);
         REG_FIELD_DELIM: prdata = CSR_DATA_W'(cfg_ff.fld_delim);
         REG_QUOTE_MODE:  prdata = CSR_DATA_W'(cfg_ff.quote_mode);
         REG_FIELD_COUNT: prdata = CSR_DATA_W'(cfg_ff.field_count);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tup_delim   <= 8'd10;
         cfg_ff.fld_delim   <= 8'd44;
         cfg_ff.quote_mode  <= 1'b1;
         cfg_ff.field_count <= FCNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/csvi_front.sv */
module csvi_front import csvi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   output logic         full,
   input  req_type      req_data,
   output logic         cmd_push,
   output cmd_type      cmd,
   input  logic         cmdq_full,
   output store_wr_type store_wr,
   input  logic         flush_done
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              seen_ff, seen_in;
   logic [POS_W-1:0]  first_ff, first_in;
   logic [POS_W-1:0]  last_ff, last_in;
   logic              inq_ff, inq_in;
   logic [FCNT_W-1:0] fields_ff, fields_in;
   logic              disc_ff, disc_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic              lock_ff, lock_in;

   logic              accept;
   logic [POS_W-1:0]  pos_next;
   logic              is_tuple;
   logic              is_field;
   logic              count_ok;

   // While a tuple's offsets are being read out, the store must not change.
   assign full     = lock_ff || cmdq_full;
   assign accept   = push && !full;
   assign pos_next = pos_ff + 1'b1;
   assign is_tuple = req_data.data_byte == cfg.tup_delim;
   assign is_field = req_data.data_byte == cfg.fld_delim;
   assign count_ok = (fields_ff == cfg.field_count) && (fields_ff != '0)
                     && (fields_ff <= FCNT_W'(FIELDS_MAX));

   always_comb begin
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      inq_in    = inq_ff;
      fields_in = fields_ff;
      disc_in   = disc_ff;
      start_in  = start_ff;
      cmd       = '0;
      store_wr  = '0;
      if (accept) begin
         if (!disc_ff) begin
            if (is_tuple) begin
               if (!seen_ff) begin
                  seen_in  = 1'b1;
                  first_in = pos_ff;
               end else if (count_ok) begin
                  cmd.flush   = 1'b1;
                  cmd.count   = fields_ff;
                  cmd.start   = start_ff;
                  cmd.end_pos = pos_ff;
               end else begin
                  cmd.error = 1'b1;
                  cmd.count = fields_ff;
                  disc_in   = 1'b1;
               end
               last_in   = pos_ff;
               start_in  = pos_next;
               fields_in = FCNT_W'(1);
               inq_in    = 1'b0;
            end else if (seen_ff) begin
               if (is_field && !(cfg.quote_mode && inq_ff)) begin
                  if (fields_ff < FCNT_W'(FIELDS_MAX)) begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = fields_ff[ADDR_W-1:0];
                     store_wr.data = pos_next;
                  end
                  if (fields_ff < FCNT_W'(FIELDS_MAX + 1)) begin
                     fields_in = fields_ff + 1'b1;
                  end
               end
               if (cfg.quote_mode && (req_data.data_byte == QUOTE_CHAR)) begin
                  inq_in = !inq_ff;
               end
            end
         end
         pos_in = pos_next;
         if (req_data.buffer_end) begin
            if (!disc_in) begin
               cmd.summ       = 1'b1;
               cmd.have_delim = seen_in;
               cmd.first      = first_in;
               cmd.last       = last_in;
            end
            pos_in    = '0;
            seen_in   = 1'b0;
            first_in  = '0;
            last_in   = '0;
            inq_in    = 1'b0;
            fields_in = '0;
            disc_in   = 1'b0;
         end
      end
   end

   assign cmd_push = cmd.flush || cmd.error || cmd.summ;

   always_comb begin
      lock_in = lock_ff;
      if (cmd_push && cmd.flush) begin
         lock_in = 1'b1;
      end else if (flush_done) begin
         lock_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         seen_ff   <= 1'b0;
         first_ff  <= '0;
         last_ff   <= '0;
         inq_ff    <= 1'b0;
         fields_ff <= '0;
         disc_ff   <= 1'b0;
         lock_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         inq_ff    <= inq_in;
         fields_ff <= fields_in;
         disc_ff   <= disc_in;
         lock_ff   <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   a_no_write_while_locked: assert property (@(posedge clock) disable iff (reset)
      lock_ff |-> !store_wr.en)
      else $error("offset store written while a flush is pending");

   a_flush_sets_lock: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd.flush) |=> lock_ff)
      else $error("flush issued without locking the input");

   a_flush_xor_error: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !(cmd.flush && cmd.error))
      else $error("one byte gave both a flush and a count error");

endmodule

/* design/csvi_cmdq.sv */
module csvi_cmdq import csvi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    empty,
   output cmd_type rd_data
);

   cmd_type               mem [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full    = cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/csvi_back.sv */
module csvi_back import csvi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmdq_empty,
   input  cmd_type      cmd,
   output logic         cmdq_pop,
   output logic         flush_done,
   input  store_wr_type store_wr,
   output logic         empty,
   input  logic         pop,
   output rsp_type      rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIELD = 3'd1;
   localparam logic [2:0] ST_END   = 3'd2;
   localparam logic [2:0] ST_ERR   = 3'd3;
   localparam logic [2:0] ST_SUMM  = 3'd4;

   logic [2:0]           st_ff, st_in;
   logic [FCNT_W-1:0]    idx_ff, idx_in;
   logic [FCNT_W-1:0]    idx_next;
   cmd_type              cur_ff, cur_in;
   logic [POS_W-1:0]     store_mem [FIELDS_MAX];
   logic [POS_W-1:0]     rdata_ff;

   rsp_type              rq_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rq_wr_ff, rq_wr_in;
   logic [RSP_PTR_W-1:0] rq_rd_ff, rq_rd_in;
   logic [RSP_CNT_W-1:0] rq_cnt_ff, rq_cnt_in;
   logic                 room;
   logic                 gen;
   logic                 rq_pop;
   rsp_type              res;

   assign room     = rq_cnt_ff != RSP_CNT_W'(RSP_DEPTH);
   assign idx_next = idx_ff + 1'b1;

   always_comb begin
      st_in      = st_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      cmdq_pop   = 1'b0;
      flush_done = 1'b0;
      gen        = 1'b0;
      res        = '0;
      case (st_ff)
         ST_IDLE: begin
            if (!cmdq_empty) begin
               cmdq_pop = 1'b1;
               cur_in   = cmd;
               idx_in   = '0;
               if (cmd.flush) begin
                  st_in = ST_FIELD;
               end else if (cmd.error) begin
                  st_in = ST_ERR;
               end else begin
                  st_in = ST_SUMM;
               end
            end
         end
         ST_FIELD: begin
            // The tuple start travels in the command; later starts come from the store.
            res.kind   = KIND_FIELD;
            res.offset = (idx_ff == '0) ? cur_ff.start : rdata_ff;
            if (room) begin
               gen    = 1'b1;
               idx_in = idx_next;
               if (idx_next == cur_ff.count) begin
                  st_in = ST_END;
               end
            end
         end
         ST_END: begin
            res.kind     = KIND_END;
            res.offset   = cur_ff.end_pos;
            res.run_last = !cur_ff.summ;
            if (room) begin
               gen        = 1'b1;
               flush_done = 1'b1;
               st_in      = cur_ff.summ ? ST_SUMM : ST_IDLE;
            end
         end
         ST_ERR: begin
            res.kind          = KIND_ERROR;
            res.parsed_fields = cur_ff.count;
            res.run_last      = 1'b1;
            if (room) begin
               gen   = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_SUMM: begin
            res.run_last = 1'b1;
            if (cur_ff.have_delim) begin
               res.kind          = KIND_SUMMARY;
               res.offset        = cur_ff.first;
               res.second_offset = cur_ff.last;
            end else begin
               res.kind = KIND_NODELIM;
            end
            if (room) begin
               gen   = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Read address follows the next index so the data lines up with idx_ff.
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rdata_ff <= store_mem[idx_in[ADDR_W-1:0]];
   end

   // Result queue.
   assign empty    = rq_cnt_ff == '0;
   assign rq_pop   = pop && !empty;
   assign rsp_data = rq_mem[rq_rd_ff];

   always_comb begin
      rq_wr_in  = gen ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (gen && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !gen) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         rq_mem[rq_wr_ff] <= res;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIELD) |-> (idx_ff < cur_ff.count))
      else $error("field index ran past the tuple's field count");

   a_done_then_summary_or_idle: assert property (@(posedge clock) disable iff (reset)
      flush_done |=> (st_ff == ST_SUMM || st_ff == ST_IDLE))
      else $error("flush finished into an unexpected state");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && !cmdq_empty) |=> (st_ff != ST_IDLE))
      else $error("command taken but no work started");

endmodule

/* design/csv_field_offset_indexer.sv */
// Channel   Ports                                           Beat taken when
// -------   ---------------------------------------------   ------------------------------
// input     push, full, req_data                            push && !full
// result    pop, empty, rsp_data                            pop && !empty
// config    psel, penable, pwrite, pready, paddr, pwdata    psel && penable && pwrite && pready
//
// A byte that does not close a tuple sets no lock; it waits only while the input is locked
// or the command queue is full. After a tuple's closing delimiter the input is held full
// while the back end reads the field starts out of the offset store, until it queues the
// tuple's end result.
// A full result queue stalls the back end, and through the command queue the input.
// Reset clears all control state; the offset store holds no reset value.
module csv_field_offset_indexer import csvi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   logic         cmd_push;
   cmd_type      cmd_wr;
   logic         cmdq_full;
   logic         cmdq_empty;
   cmd_type      cmd_head;
   logic         cmdq_pop;
   logic         flush_done;
   store_wr_type store_wr;

   csvi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   csvi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .cmd_push   (cmd_push),
      .cmd        (cmd_wr),
      .cmdq_full  (cmdq_full),
      .store_wr   (store_wr),
      .flush_done (flush_done)
   );

   csvi_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmdq_full),
      .rd_en   (cmdq_pop),
      .empty   (cmdq_empty),
      .rd_data (cmd_head)
   );

   csvi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_empty (cmdq_empty),
      .cmd        (cmd_head),
      .cmdq_pop   (cmdq_pop),
      .flush_done (flush_done),
      .store_wr   (store_wr),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* verif/csv_field_offset_indexer_tb.sv */
`timescale 1ns / 1ps

module csv_field_offset_indexer_tb;
   import csvi_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          SETTLE      = 40;
   localparam logic [7:0]  NEWLINE     = 8'h0A;
   localparam logic [7:0]  COMMA       = 8'h2C;

   logic                  clock;
   logic                  reset   = 1'b1;
   logic                  push    = 1'b0;
   logic                  full;
   req_type               req_data = '0;
   logic                  empty;
   logic                  pop     = 1'b0;
   rsp_type               rsp_data;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   csv_field_offset_indexer DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Register copies as the indexer should hold them.
   logic [7:0]        cfg_tuple_delim = 8'h0A;
   logic [7:0]        cfg_field_delim = 8'h2C;
   logic              cfg_quote       = 1'b1;
   logic [FCNT_W-1:0] cfg_fields      = FCNT_W'(1);

   // Buffer state of the offset predictor.
   logic [POS_W-1:0]  next_pos        = '0;
   logic              delim_seen      = 1'b0;
   logic [POS_W-1:0]  first_delim_pos = '0;
   logic [POS_W-1:0]  last_delim_pos  = '0;
   logic              quoted          = 1'b0;
   int                field_total     = 0;
   logic [POS_W-1:0]  field_starts[FIELDS_MAX];
   logic              skip_rest       = 1'b0;

   rsp_type           offsets_due[$];
   logic [7:0]        frame_bytes[$];

   int   mismatches  = 0;
   int   cycle_count = 0;
   logic idles_on    = 1'b1;
   logic rx_hold     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_offset(input logic [2:0] kind, input logic [POS_W-1:0] off,
                               input logic [POS_W-1:0] off2, input int parsed);
      rsp_type r;
      r = '0;
      r.kind          = kind;
      r.offset        = off;
      r.second_offset = off2;
      r.parsed_fields = parsed[FCNT_W-1:0];
      offsets_due.push_back(r);
   endtask

   // Works out what one accepted byte makes the indexer emit.
   task automatic index_byte(input logic [7:0] b, input logic last);
      logic [POS_W-1:0] p;
      int               base;
      int               i;
      rsp_type          r;
      p    = next_pos;
      base = offsets_due.size();
      if (!skip_rest) begin
         if (b == cfg_tuple_delim) begin
            if (!delim_seen) begin
               delim_seen      = 1'b1;
               first_delim_pos = p;
            end else if (field_total == cfg_fields && field_total >= 1 &&
                         field_total <= FIELDS_MAX) begin
               for (i = 0; i < field_total; i++)
                  queue_offset(KIND_FIELD, field_starts[i], '0, 0);
               queue_offset(KIND_END, p, '0, 0);
            end else begin
               queue_offset(KIND_ERROR, '0, '0, field_total);
               skip_rest = 1'b1;
            end
            last_delim_pos  = p;
            field_starts[0] = p + 1'b1;
            field_total     = 1;
            quoted          = 1'b0;
         end else if (delim_seen) begin
            if (b == cfg_field_delim && !(cfg_quote && quoted)) begin
               if (field_total < FIELDS_MAX)
                  field_starts[field_total] = p + 1'b1;
               if (field_total < FIELDS_MAX + 1)
                  field_total++;
            end
            if (cfg_quote && b == QUOTE_CHAR)
               quoted = !quoted;
         end
      end
      next_pos = p + 1'b1;
      if (last) begin
         if (!skip_rest) begin
            if (delim_seen)
               queue_offset(KIND_SUMMARY, first_delim_pos, last_delim_pos, 0);
            else
               queue_offset(KIND_NODELIM, '0, '0, 0);
         end
         next_pos        = '0;
         delim_seen      = 1'b0;
         first_delim_pos = '0;
         last_delim_pos  = '0;
         quoted          = 1'b0;
         field_total     = 0;
         skip_rest       = 1'b0;
      end
      if (offsets_due.size() > base) begin
         r = offsets_due.pop_back();
         r.run_last = 1'b1;
         offsets_due.push_back(r);
      end
   endtask

   task automatic check_offset_beat(input rsp_type got);
      rsp_type want;
      if (offsets_due.size() == 0) begin
         flag_mismatch($sformatf("result beat with none pending, kind %0d offset %0d",
                                 got.kind, got.offset));
         return;
      end
      want = offsets_due.pop_front();
      if (got.kind !== want.kind)
         flag_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.offset !== want.offset)
         flag_mismatch($sformatf("offset got %0d want %0d", got.offset, want.offset));
      if (got.second_offset !== want.second_offset)
         flag_mismatch($sformatf("second_offset got %0d want %0d",
                                 got.second_offset, want.second_offset));
      if (got.parsed_fields !== want.parsed_fields)
         flag_mismatch($sformatf("parsed_fields got %0d want %0d",
                                 got.parsed_fields, want.parsed_fields));
      if (got.run_last !== want.run_last)
         flag_mismatch($sformatf("run_last got %0d want %0d", got.run_last, want.run_last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            check_offset_beat(rsp_data);
         pop <= !rx_hold && !(idles_on && $urandom_range(0, 99) < 25);
      end
   end

   // Leaves push high on return so that the next byte can follow without a gap.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (idles_on && $urandom_range(0, 99) < 25) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                <= 1'b1;
      req_data.data_byte  <= b;
      req_data.buffer_end <= last;
      do @(posedge clock); while (full);
      index_byte(b, last);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (offsets_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] reg_mask(input logic [1:0] idx);
      case (idx)
         REG_TUPLE_DELIM: reg_mask = 32'hFF;
         REG_FIELD_DELIM: reg_mask = 32'hFF;
         REG_QUOTE_MODE:  reg_mask = 32'h1;
         default:         reg_mask = (32'd1 << FCNT_W) - 1;
      endcase
   endfunction

   // Write, then read back through the same port.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] rd;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_TUPLE_DELIM: cfg_tuple_delim = val[7:0];
         REG_FIELD_DELIM: cfg_field_delim = val[7:0];
         REG_QUOTE_MODE:  cfg_quote       = val[0];
         default:         cfg_fields      = val[FCNT_W-1:0];
      endcase
      if (rd !== (val & reg_mask(idx)))
         flag_mismatch($sformatf("register %0d read %0h want %0h", idx, rd,
                                 val & reg_mask(idx)));
   endtask

   task automatic set_config(input logic [7:0] tdel, input logic [7:0] fdel,
                             input logic quote, input int count);
      wait_drained();
      write_reg(REG_TUPLE_DELIM, {24'd0, tdel});
      write_reg(REG_FIELD_DELIM, {24'd0, fdel});
      write_reg(REG_QUOTE_MODE, {31'd0, quote});
      write_reg(REG_FIELD_COUNT, count);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == cfg_tuple_delim || b == cfg_field_delim || b == QUOTE_CHAR);
      return b;
   endfunction

   task automatic add_plain(input int n);
      repeat (n) frame_bytes.push_back(plain_byte());
   endtask

   task automatic add_tuple(input int nf);
      int f;
      for (f = 0; f < nf; f++) begin
         if (f > 0)
            frame_bytes.push_back(cfg_field_delim);
         if ($urandom_range(0, 3) == 0) begin
            frame_bytes.push_back(QUOTE_CHAR);
            add_plain($urandom_range(0, 2));
            // A separator hidden in quotes only stays one field in quote mode.
            if (cfg_quote && $urandom_range(0, 1))
               frame_bytes.push_back(cfg_field_delim);
            add_plain($urandom_range(0, 2));
            frame_bytes.push_back(QUOTE_CHAR);
         end else begin
            add_plain($urandom_range(0, 3));
         end
      end
      frame_bytes.push_back(cfg_tuple_delim);
   endtask

   // Mostly well-formed buffers with random content, some malformed ones and noise.
   task automatic build_buffer();
      int sel;
      int good;
      int t;
      sel  = $urandom_range(0, 99);
      good = (cfg_fields >= 1 && cfg_fields <= FIELDS_MAX) ? cfg_fields
                                                            : $urandom_range(1, 4);
      if (sel < 12) begin
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 16) begin
         add_plain($urandom_range(1, 6));
      end else begin
         add_plain($urandom_range(0, 3));
         frame_bytes.push_back(cfg_tuple_delim);
         repeat ($urandom_range(1, good > 8 ? 2 : 5)) begin
            if ($urandom_range(0, 99) < 10)
               add_tuple($urandom_range(1, FIELDS_MAX + 2));
            else
               add_tuple(good);
         end
         add_plain($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frame_bytes.delete();
   endtask

   task automatic run_traffic(input int nbytes);
      int sent;
      sent = 0;
      while (sent < nbytes) begin
         build_buffer();
         sent += frame_bytes.size();
         send_frame();
      end
   endtask

   // Reset defaults: no delimiter at all, quoted separators; then quote mode off and a count error.
   task automatic test_basic_tuples();
      send_byte(8'h00, 1'b0);
      send_byte("a", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(NEWLINE, 1'b0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte(QUOTE_CHAR, 1'b0);
      send_byte(COMMA, 1'b0);
      send_byte(QUOTE_CHAR, 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte("z", 1'b1);
      set_config(NEWLINE, COMMA, 1'b0, 2);
      send_byte(NEWLINE, 1'b0);
      send_byte(QUOTE_CHAR, 1'b0);
      send_byte(COMMA, 1'b0);
      send_byte(QUOTE_CHAR, 1'b0);
      send_byte(NEWLINE, 1'b1);
      // One field where two are due; the rest of the buffer is dropped.
      send_byte(NEWLINE, 1'b0);
      send_byte("a", 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte("b", 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte(COMMA, 1'b1);
   endtask

   task automatic test_equal_delimiters();
      set_config(COMMA, COMMA, 1'b1, 1);
      send_byte(COMMA, 1'b0);
      send_byte("a", 1'b0);
      send_byte(COMMA, 1'b0);
      send_byte(COMMA, 1'b1);
   endtask

   task automatic test_field_limits();
      set_config(NEWLINE, COMMA, 1'b1, FIELDS_MAX);
      send_byte(NEWLINE, 1'b0);
      repeat (FIELDS_MAX - 1) send_byte(COMMA, 1'b0);
      send_byte(NEWLINE, 1'b0);
      repeat (FIELDS_MAX + 8) send_byte(COMMA, 1'b0);
      send_byte(NEWLINE, 1'b1);
      set_config(NEWLINE, COMMA, 1'b1, 0);
      send_byte(NEWLINE, 1'b0);
      send_byte("a", 1'b0);
      send_byte(NEWLINE, 1'b1);
      set_config(NEWLINE, COMMA, 1'b1, 63);
      send_byte(NEWLINE, 1'b0);
      send_byte("a", 1'b0);
      send_byte(NEWLINE, 1'b1);
   endtask

   task automatic test_random_settings();
      set_config(NEWLINE, COMMA, 1'b1, 3);
      run_traffic(40);
      set_config(8'h00, 8'hFF, 1'b0, 1);
      run_traffic(25);
      set_config(8'hFF, 8'h00, 1'b1, FIELDS_MAX);
      run_traffic(20);
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), $urandom_range(1, 6));
      run_traffic(30);
   endtask

   task automatic test_no_idling();
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), $urandom_range(1, 6));
      idles_on = 1'b0;
      run_traffic(50);
      wait_drained();
      idles_on = 1'b1;
   endtask

   // The receiver stops long enough for the result queue and then the input to fill.
   task automatic test_backpressure();
      set_config(NEWLINE, COMMA, 1'b1, 6);
      fork
         begin
            rx_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rx_hold <= 1'b0;
         end
      join_none
      run_traffic(60);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_tuples();
      test_equal_delimiters();
      test_field_limits();
      test_random_settings();
      test_no_idling();
      test_backpressure();
      wait_drained();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
design/csvi_pkg.sv
design/csvi_csr.sv
design/csvi_front.sv
design/csvi_cmdq.sv
design/csvi_back.sv
design/csv_field_offset_indexer.sv
verif/csv_field_offset_indexer_tb.sv
